FILE: rtl/sfcc_pkg.sv
// sfcc_pkg: shared types and constants for the sensor frame check and conversion pipeline.
// No dependencies.
package sfcc_pkg;

  localparam int RawW   = 16;
  localparam int ProdTW = 27;  // raw * 1750 < 2^27
  localparam int ProdHW = 23;  // (raw - 512) * 125 < 2^23
  localparam int QtW    = 11;
  localparam int QhW    = 7;
  localparam int ReadW  = 11;

  localparam logic [8:0]   CrcPoly   = 9'h131;
  localparam logic [10:0]  TScale    = 11'd1750;
  localparam logic [10:0]  TOffset   = 11'd50;
  localparam logic [10:0]  TLow      = 11'd100;
  localparam logic [10:0]  THigh     = 11'd1750;
  localparam logic [15:0]  HBias     = 16'd512;
  localparam logic [6:0]   HScale    = 7'd125;
  localparam logic [QhW-1:0] HSub    = 7'd6;
  localparam logic [ReadW-1:0] HHigh = 11'd200;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_RANGE = 2'd1,
    FAULT_CRC   = 2'd2
  } fault_t;

  typedef struct packed {
    logic            kind;
    logic            ok;
    logic [QtW-1:0]  qt;
    logic [QhW-1:0]  qh;
  } quot_t;

  typedef struct packed {
    logic              kind;
    logic              ok;
    logic [ReadW-1:0]  reading;
    fault_t            fault;
  } result_t;

endpackage

FILE: rtl/sensor_frame_crc_convert_unit.sv
// sensor_frame_crc_convert_unit: four-stage pipeline that checks a sensor frame CRC and
// scales the reading. Depends on sfcc_pkg, sfcc_crc, sfcc_mult, sfcc_clamp.
//
//  channel  dir  tdata (low bit up)                          tuser
//  s_*      in   raw_high[7:0] raw_low[15:8] check_byte[23:16] kind
//  m_*      out  check_ok[0] reading[11:1] fault[13:12] 0[15:14] kind_echo
//
// One request per cycle while m_tready is high; the stages are CRC high byte, CRC low
// byte with products, quotient, and clamp into the output register.
// Synchronous reset clears the stage valid bits only.
// Each stage holds while its successor is full and stalled; bubbles are filled,
// so s_tready drops only when all four stages are full and m_tready is low.
module sensor_frame_crc_convert_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // raw_high, raw_low, check_byte
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // check_ok, reading, fault, zero pad
  output logic        m_tuser    // kind_echo
);
  import sfcc_pkg::*;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1
  logic            s1_kind;
  logic [RawW-1:0] s1_raw;
  logic [7:0]      s1_chk;
  logic [7:0]      s1_crc;
  // stage 2
  logic              s2_kind;
  logic              s2_ok;
  logic [ProdTW-1:0] s2_prod_t;
  logic [ProdHW-1:0] s2_prod_h;
  // stage 3
  quot_t   s3;
  // stage 4
  result_t s4;

  logic [7:0]        crc_hi;
  logic [7:0]        crc_lo;
  logic [ProdTW-1:0] prod_t;
  logic [ProdHW-1:0] prod_h;
  logic [ProdTW-1:0] qsum;
  quot_t             s3_next;
  result_t           s4_next;

  assign rdy4     = !v4 || m_tready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  sfcc_crc u_crc_hi (.crc_in(8'h00), .data(s_tdata[7:0]), .crc_out(crc_hi));
  sfcc_crc u_crc_lo (.crc_in(s1_crc), .data(s1_raw[7:0]), .crc_out(crc_lo));
  sfcc_mult u_mult (.raw(s1_raw), .prod_t(prod_t), .prod_h(prod_h));

  // floor(p / 65535) = (p + (p >> 16) + 1) >> 16 over this range
  assign qsum         = s2_prod_t + ProdTW'(s2_prod_t >> 16) + ProdTW'(1);
  assign s3_next.kind = s2_kind;
  assign s3_next.ok   = s2_ok;
  assign s3_next.qt   = QtW'(qsum >> 16);
  assign s3_next.qh   = QhW'(s2_prod_h >> 16);

  sfcc_clamp u_clamp (.q(s3), .res(s4_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      s1_kind <= s_tuser;
      s1_raw  <= {s_tdata[7:0], s_tdata[15:8]};
      s1_chk  <= s_tdata[23:16];
      s1_crc  <= crc_hi;
    end
    if (rdy2 && v1) begin
      s2_kind   <= s1_kind;
      s2_ok     <= (crc_lo == s1_chk);
      s2_prod_t <= prod_t;
      s2_prod_h <= prod_h;
    end
    if (rdy3 && v2) begin
      s3 <= s3_next;
    end
    if (rdy4 && v3) begin
      s4 <= s4_next;
    end
  end

  assign m_tvalid = v4;
  assign m_tuser  = s4.kind;
  assign m_tdata  = {2'b00, s4.fault, s4.reading, s4.ok};

  a_crc_fail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[13:12] == FAULT_CRC) && (m_tdata[11:1] == '0))
    else $error("bad checksum result not zeroed");

  a_ok_no_crc_fault: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[13:12] != FAULT_CRC)
    else $error("crc fault with good checksum");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] && !m_tuser |-> m_tdata[11:1] >= TLow && m_tdata[11:1] <= THigh)
    else $error("temperature reading out of range");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[11:1] <= HHigh && !m_tdata[1])
    else $error("humidity reading out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && v4 && !m_tready |=> v3 && v4)
    else $error("stalled stage dropped a request");

endmodule

FILE: rtl/sfcc_crc.sv
// sfcc_crc: one byte of CRC-8 (poly 0x31, MSB first), bitwise XOR network.
// Depends on sfcc_pkg.
module sfcc_crc (
  input  logic [7:0] crc_in,
  input  logic [7:0] data,
  output logic [7:0] crc_out
);
  import sfcc_pkg::*;

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly[7:0];
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

FILE: rtl/sfcc_mult.sv
// sfcc_mult: constant-coefficient products for temperature and humidity scaling.
// Depends on sfcc_pkg.
module sfcc_mult (
  input  logic [sfcc_pkg::RawW-1:0]   raw,
  output logic [sfcc_pkg::ProdTW-1:0] prod_t,
  output logic [sfcc_pkg::ProdHW-1:0] prod_h
);
  import sfcc_pkg::*;

  logic [RawW-1:0] x;

  assign x      = (raw > HBias) ? (raw - HBias) : '0;
  assign prod_t = ProdTW'(raw) * ProdTW'(TScale);
  assign prod_h = ProdHW'(x) * ProdHW'(HScale);

endmodule

FILE: rtl/sfcc_clamp.sv
// sfcc_clamp: offset, saturation, clamp and fault selection of the final stage.
// Depends on sfcc_pkg.
module sfcc_clamp (
  input  sfcc_pkg::quot_t   q,
  output sfcc_pkg::result_t res
);
  import sfcc_pkg::*;

  logic [ReadW-1:0] t;
  logic [ReadW-1:0] h;

  assign t = q.qt + TOffset;
  assign h = (q.qh < HSub) ? '0 : ReadW'({q.qh - HSub, 1'b0});

  always_comb begin
    res.kind    = q.kind;
    res.ok      = q.ok;
    res.reading = '0;
    res.fault   = FAULT_NONE;
    if (!q.ok) begin
      res.fault = FAULT_CRC;
    end else if (!q.kind) begin
      if (t > THigh) begin
        res.reading = THigh;
        res.fault   = FAULT_RANGE;
      end else if (t < TLow) begin
        res.reading = TLow;
        res.fault   = FAULT_RANGE;
      end else begin
        res.reading = t;
      end
    end else begin
      if (q.qh < HSub) begin
        res.fault = FAULT_RANGE;
      end
      if (h > HHigh) begin
        res.reading = HHigh;
        res.fault   = FAULT_RANGE;
      end else begin
        res.reading = h;
      end
    end
  end

endmodule
